// ----- rtl/cascaded_biquad_iir_filter_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded biquad filter
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_IIR_FILTER_TOP_MACROS_SVH
`define CASCADED_BIQUAD_IIR_FILTER_TOP_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define CBQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CBQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CBQ_ASSERT_IMP(lbl, ante, cons, msg)
`define CBQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/cbq_pkg.sv -----
// ----------------------------------------------------------------------------
// cbq_pkg
// Shared constants, register indices and control types of the biquad cascade.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbq_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 18;
  localparam int FRAC_BITS      = 16;
  localparam int NUM_LANES      = 5;
  localparam int LANE_IDX_W     = 3;
  localparam int BIT_CNT_W      = $clog2(COEF_W);
  localparam int CFG_IDX_W      = 3;
  localparam int NUM_STAGES_DEF = 4;
  localparam int STATE_W_DEF    = 24;

  // register indices, also the lane that carries each coefficient
  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EN = 3'd5;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic [NUM_LANES-1:0][COEF_W-1:0] cbq_coef_vec_t;

  // bit-serial multiplier lane control
  typedef struct packed {
    logic load;   // reload coefficient shifter, clear product
    logic step;   // consume one coefficient bit, MSB first
    logic first;  // current bit is the sign bit
  } cbq_lane_ctrl_t;

  // datapath control
  typedef struct packed {
    cbq_lane_ctrl_t          lane;
    logic                    sum_en;   // fold one lane product into the sum
    logic [LANE_IDX_W-1:0]   sum_idx;  // lane being folded
    logic                    upd;      // finish stage, rotate delay lines
    logic                    take;     // load new input sample
    logic                    clr;      // clear delay lines
  } cbq_dp_ctrl_t;

endpackage

// ----- rtl/cascaded_biquad_iir_filter_top.sv -----
// ----------------------------------------------------------------------------
// cascaded_biquad_iir_filter_top
// Cascade of direct-form-I biquads sharing one coefficient set, Q15 samples.
// ----------------------------------------------------------------------------
//   in_valid/in_ready/in_sample_in takes one Q15 sample per transfer;
//   out_valid/out_ready/out_sample_out returns one saturated sample per
//   input, in order. cfg_wr_en with cfg_index and cfg_data writes one
//   register (b0, b1, b2, a1, a2, enable); write only while idle. Any
//   coefficient write clears every stage's delay state.
//   Each stage: bit-serial multiply (five lanes in parallel), then summing
//   the lane products, then rounding and update. With enable low the
//   sample bypasses the stages. in_ready is high only while no sample is
//   being processed, so a new sample waits until the last one has been
//   handed to the output register.
//   A stalled result waits in the output register; the next sample may be
//   accepted and processed, and waits at its own output step.
//   Reset (synchronous, rst_n low) clears coefficients, enable, delay state
//   and the output valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascaded_biquad_iir_filter_top_macros.svh"

module cascaded_biquad_iir_filter_top
  import cbq_pkg::*;
#(
  parameter int NUM_STAGES  = NUM_STAGES_DEF,
  parameter int STATE_WIDTH = STATE_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COEF_W-1:0]          cfg_data
);

  localparam int STG_W = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam logic [STG_W-1:0]      STG_LAST = STG_W'(NUM_STAGES - 1);
  localparam logic [BIT_CNT_W-1:0]  BIT_LAST = BIT_CNT_W'(COEF_W - 1);
  localparam logic [LANE_IDX_W-1:0] SUM_LAST = LANE_IDX_W'(NUM_LANES - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SUM  = 5'b00100,
    S_UPD  = 5'b01000,
    S_OUT  = 5'b10000
  } cbq_state_t;

  cbq_state_t state_r, state_nxt;
  logic [BIT_CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [LANE_IDX_W-1:0] sum_cnt_r, sum_cnt_nxt;
  logic [STG_W-1:0]      stg_cnt_r, stg_cnt_nxt;

  cbq_coef_vec_t coef_r;
  logic          en_r;
  logic          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  cbq_dp_ctrl_t ctrl;
  logic signed [SAMPLE_W-1:0] dp_result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      en_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_B0:  coef_r[REG_B0] <= cfg_data;
        REG_B1:  coef_r[REG_B1] <= cfg_data;
        REG_B2:  coef_r[REG_B2] <= cfg_data;
        REG_A1:  coef_r[REG_A1] <= cfg_data;
        REG_A2:  coef_r[REG_A2] <= cfg_data;
        REG_EN:  en_r           <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    bit_cnt_nxt    = bit_cnt_r;
    sum_cnt_nxt    = sum_cnt_r;
    stg_cnt_nxt    = stg_cnt_r;
    out_valid_nxt  = out_valid_r;
    out_sample_nxt = out_sample_r;
    ctrl.lane      = '0;
    ctrl.sum_en    = 1'b0;
    ctrl.sum_idx   = sum_cnt_r;
    ctrl.upd       = 1'b0;
    ctrl.take      = 1'b0;
    // coefficient writes clear the delay state
    ctrl.clr       = cfg_wr_en &&
                     (cfg_index inside {REG_B0, REG_B1, REG_B2, REG_A1, REG_A2});

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.take = 1'b1;
          if (en_r) begin
            ctrl.lane.load = 1'b1;
            bit_cnt_nxt    = '0;
            stg_cnt_nxt    = '0;
            state_nxt      = S_MUL;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_MUL: begin
        ctrl.lane.step  = 1'b1;
        ctrl.lane.first = (bit_cnt_r == '0);
        bit_cnt_nxt     = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_LAST) begin
          sum_cnt_nxt = '0;
          state_nxt   = S_SUM;
        end
      end
      S_SUM: begin
        ctrl.sum_en = 1'b1;
        sum_cnt_nxt = sum_cnt_r + 1'b1;
        if (sum_cnt_r == SUM_LAST) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        ctrl.upd = 1'b1;
        if (stg_cnt_r == STG_LAST) begin
          state_nxt = S_OUT;
        end else begin
          stg_cnt_nxt    = stg_cnt_r + 1'b1;
          bit_cnt_nxt    = '0;
          ctrl.lane.load = 1'b1;
          state_nxt      = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = dp_result;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      sum_cnt_r   <= '0;
      stg_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      sum_cnt_r   <= sum_cnt_nxt;
      stg_cnt_r   <= stg_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  cbq_datapath #(
    .NUM_STAGES  (NUM_STAGES),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coef      (coef_r),
    .in_sample (in_sample_in),
    .result    (dp_result)
  );

  // checks
  `CBQ_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready && en_r, !in_ready, "ready after filtered transfer")
  `CBQ_ASSERT_IMP(a_out_from_out_state, $rose(out_valid_r), $past(state_r == S_OUT), "result raised outside output step")
  `CBQ_ASSERT_NXT(a_sum_after_bits, state_r == S_MUL && bit_cnt_r == BIT_LAST, state_r == S_SUM, "summation not entered after last coefficient bit")

endmodule

// ----- rtl/cbq_mac_lane.sv -----
// ----------------------------------------------------------------------------
// cbq_mac_lane
// Bit-serial signed multiplier: coefficient shifted out MSB first, one bit a
// cycle, product built by shift-and-add into a full-precision accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbq_mac_lane
  import cbq_pkg::*;
#(
  parameter int OP_W = STATE_W_DEF
) (
  input  logic                             clk,
  input  cbq_lane_ctrl_t                   ctrl,
  input  logic        [COEF_W-1:0]         coef,
  input  logic signed [OP_W-1:0]           op,
  output logic signed [OP_W+COEF_W-1:0]    prod
);

  localparam int ACC_W = OP_W + COEF_W;

  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic        [COEF_W-1:0] csr_r, csr_nxt;
  logic signed [ACC_W-1:0]  op_ext;
  logic signed [ACC_W-1:0]  pp;

  assign op_ext = ACC_W'(op);

  // partial product: sign bit of the coefficient carries negative weight
  always_comb begin
    pp = '0;
    if (csr_r[COEF_W-1]) begin
      pp = ctrl.first ? -op_ext : op_ext;
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    csr_nxt = csr_r;
    if (ctrl.load) begin
      acc_nxt = '0;
      csr_nxt = coef;
    end else if (ctrl.step) begin
      acc_nxt = (acc_r <<< 1) + pp;
      csr_nxt = csr_r << 1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    csr_r <= csr_nxt;
  end

  assign prod = acc_r;

endmodule

// ----- rtl/cbq_datapath.sv -----
// ----------------------------------------------------------------------------
// cbq_datapath
// Five multiplier lanes, product summation, rounding and saturation, and the
// per-stage delay lines held as rotating shift lines (current stage at tap 0).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbq_datapath
  import cbq_pkg::*;
#(
  parameter int NUM_STAGES  = NUM_STAGES_DEF,
  parameter int STATE_WIDTH = STATE_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cbq_dp_ctrl_t               ctrl,
  input  cbq_coef_vec_t              coef,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int ACC_W = STATE_WIDTH + COEF_W;
  localparam int SUM_W = ACC_W + 3;
  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
  localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};

  logic signed [STATE_WIDTH-1:0] x_r, x_nxt;
  logic signed [STATE_WIDTH-1:0] xin1_r  [NUM_STAGES];
  logic signed [STATE_WIDTH-1:0] xin2_r  [NUM_STAGES];
  logic signed [STATE_WIDTH-1:0] yout1_r [NUM_STAGES];
  logic signed [STATE_WIDTH-1:0] yout2_r [NUM_STAGES];

  logic signed [STATE_WIDTH-1:0] ops  [NUM_LANES];
  logic signed [ACC_W-1:0]       prod [NUM_LANES];

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic signed [SUM_W-1:0] sum_base, prod_ext;
  logic signed [SUM_W-1:0] rsum, rsh;
  logic signed [STATE_WIDTH-1:0] y_stage;
  logic [SUM_W-STATE_WIDTH:0] rsh_top;
  logic [STATE_WIDTH-SAMPLE_W:0] x_top;

  // lane operands: stage input, past inputs, past outputs
  assign ops[REG_B0] = x_r;
  assign ops[REG_B1] = xin1_r[0];
  assign ops[REG_B2] = xin2_r[0];
  assign ops[REG_A1] = yout1_r[0];
  assign ops[REG_A2] = yout2_r[0];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    cbq_mac_lane #(
      .OP_W (STATE_WIDTH)
    ) u_lane (
      .clk  (clk),
      .ctrl (ctrl.lane),
      .coef (coef[g]),
      .op   (ops[g]),
      .prod (prod[g])
    );
  end

  // fold lane products one per cycle; feedback terms subtracted
  always_comb begin
    sum_base = (ctrl.sum_idx == REG_B0) ? '0 : sum_r;
    prod_ext = SUM_W'(prod[ctrl.sum_idx]);
    sum_nxt  = sum_r;
    if (ctrl.sum_en) begin
      if (ctrl.sum_idx == REG_A1 || ctrl.sum_idx == REG_A2) begin
        sum_nxt = sum_base - prod_ext;
      end else begin
        sum_nxt = sum_base + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  // round half up to Q15, saturate to state width
  always_comb begin
    rsum    = sum_r + RND_HALF;
    rsh     = rsum >>> FRAC_BITS;
    rsh_top = rsh[SUM_W-1:STATE_WIDTH-1];
    if (&rsh_top || ~|rsh_top) begin
      y_stage = rsh[STATE_WIDTH-1:0];
    end else begin
      y_stage = rsh[SUM_W-1] ? ST_MIN : ST_MAX;
    end
  end

  // stage input register
  always_comb begin
    x_nxt = x_r;
    if (ctrl.take) begin
      x_nxt = STATE_WIDTH'(in_sample);
    end else if (ctrl.upd) begin
      x_nxt = y_stage;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // delay lines: rotate one place per finished stage
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        xin1_r[i]  <= '0;
        xin2_r[i]  <= '0;
        yout1_r[i] <= '0;
        yout2_r[i] <= '0;
      end
    end else if (ctrl.upd) begin
      for (int i = 0; i < NUM_STAGES - 1; i++) begin
        xin1_r[i]  <= xin1_r[i+1];
        xin2_r[i]  <= xin2_r[i+1];
        yout1_r[i] <= yout1_r[i+1];
        yout2_r[i] <= yout2_r[i+1];
      end
      xin1_r[NUM_STAGES-1]  <= x_r;
      xin2_r[NUM_STAGES-1]  <= xin1_r[0];
      yout1_r[NUM_STAGES-1] <= y_stage;
      yout2_r[NUM_STAGES-1] <= yout1_r[0];
    end
  end

  // output saturation to Q15
  always_comb begin
    x_top = x_r[STATE_WIDTH-1:SAMPLE_W-1];
    if (&x_top || ~|x_top) begin
      result = x_r[SAMPLE_W-1:0];
    end else begin
      result = x_r[STATE_WIDTH-1] ? SAMPLE_MIN : SAMPLE_MAX;
    end
  end

endmodule
